[hdl/zrpd_pkg.sv]
package zrpd_pkg;

    // input item function codes
    localparam logic [1:0] FUNC_PAL_WR = 2'd0;
    localparam logic [1:0] FUNC_BYTE   = 2'd1;
    localparam logic [1:0] FUNC_START  = 2'd2;

    // configuration register indexes
    localparam int CFG_ADDR_W = 2;
    localparam logic [CFG_ADDR_W-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_HEIGHT = 2'd1;

    localparam logic [31:0] OPAQUE_ALPHA = 32'hFF00_0000;

    // work handed from front to back
    typedef enum logic [1:0] {
        CMD_PAL_WR,
        CMD_PIXEL,
        CMD_RUN
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind   kind;
        logic [7:0]  idx;     // palette index (write or lookup)
        logic [23:0] color;   // palette write data
        logic [7:0]  run;     // transparent run length
        logic        last;    // fills final pixel
    } t_cmd;

    typedef struct packed {
        logic [31:0] argb;
        logic [7:0]  color_index;
        logic [7:0]  repeat_res;
        logic        last_of_image;
    } t_result;

endpackage

[hdl/zrpd_ram.sv]
module zrpd_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/zrpd_fifo.sv]
module zrpd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [WIDTH-1:0]           i_wdata,
    input  logic                       i_pop,
    output logic [WIDTH-1:0]           o_rdata,
    output logic                       o_empty,
    output logic                       o_full,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wptr, r_rptr;
    logic [CW-1:0]    r_count;
    logic             wr, rd;

    assign wr = i_push && !o_full;
    assign rd = i_pop && !o_empty;

    // storage, no reset on payload
    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (wr) begin
                r_wptr <= (r_wptr == LAST_PTR) ? '0 : r_wptr + 1'b1;
            end
            if (rd) begin
                r_rptr <= (r_rptr == LAST_PTR) ? '0 : r_rptr + 1'b1;
            end
            if (wr && !rd) begin
                r_count <= r_count + 1'b1;
            end else if (rd && !wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_rdata = r_mem[r_rptr];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CW'(DEPTH));
    assign o_count = r_count;

endmodule

[hdl/zrpd_front.sv]
module zrpd_front
    import zrpd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration
    input  logic                  i_cfg_valid,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [15:0]           i_cfg_data,
    // input beats
    input  logic                  i_accept,
    input  logic [1:0]            i_func,
    input  logic [7:0]            i_data_byte,
    input  logic [7:0]            i_pal_index,
    input  logic [23:0]           i_pal_color,
    // to command queue
    input  logic                  i_cmd_full,
    output logic                  o_cmd_push,
    output t_cmd                  o_cmd
);

    logic [15:0] r_width, r_height;
    logic [31:0] r_pixels_left, n_pixels_left;
    logic        r_expect, n_expect;
    logic [7:0]  run_req;
    logic        run_clip;

    // configuration registers, used at the next start
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 16'd1;
            r_height <= 16'd1;
        end else if (i_cfg_valid) begin
            if (i_cfg_addr == CFG_WIDTH) begin
                r_width <= i_cfg_data;
            end else if (i_cfg_addr == CFG_HEIGHT) begin
                r_height <= i_cfg_data;
            end
        end
    end

    // zero count means one pixel; clip to what is left
    assign run_req  = (i_data_byte == 8'd0) ? 8'd1 : i_data_byte;
    assign run_clip = ({24'd0, run_req} >= r_pixels_left);

    // classify the beat
    always_comb begin
        n_pixels_left = r_pixels_left;
        n_expect      = r_expect;
        o_cmd_push    = 1'b0;
        o_cmd.kind    = CMD_PAL_WR;
        o_cmd.idx     = i_pal_index;
        o_cmd.color   = i_pal_color;
        o_cmd.run     = run_req;
        o_cmd.last    = 1'b0;
        if (i_accept) begin
            unique case (i_func)
                FUNC_PAL_WR: begin
                    o_cmd_push = 1'b1;
                end
                FUNC_START: begin
                    n_pixels_left = {16'd0, r_width} * {16'd0, r_height};
                    n_expect      = 1'b0;
                end
                FUNC_BYTE: begin
                    if (r_pixels_left != 32'd0) begin
                        if (r_expect) begin
                            n_expect   = 1'b0;
                            o_cmd_push = 1'b1;
                            o_cmd.kind = CMD_RUN;
                            if (run_clip) begin
                                o_cmd.run     = r_pixels_left[7:0];
                                o_cmd.last    = 1'b1;
                                n_pixels_left = 32'd0;
                            end else begin
                                n_pixels_left = r_pixels_left - {24'd0, run_req};
                            end
                        end else if (i_data_byte == 8'd0) begin
                            n_expect = 1'b1;
                        end else begin
                            o_cmd_push    = 1'b1;
                            o_cmd.kind    = CMD_PIXEL;
                            o_cmd.idx     = i_data_byte;
                            o_cmd.last    = (r_pixels_left == 32'd1);
                            n_pixels_left = r_pixels_left - 32'd1;
                        end
                    end
                end
                default: begin
                    // unused function code: ignored
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixels_left <= 32'd0;
            r_expect      <= 1'b0;
        end else begin
            r_pixels_left <= n_pixels_left;
            r_expect      <= n_expect;
        end
    end

`ifndef NO_ASSERTIONS
    // pixel count only grows at a start beat
    a_left_monotone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_accept && i_func == FUNC_START) |=> r_pixels_left <= $past(r_pixels_left))
        else $error("pixel count grew without start");

    // no command is produced into a full queue
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_push |-> !i_cmd_full)
        else $error("command pushed into full queue");

    // a last-of-image command leaves the image complete
    a_last_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd_push && o_cmd.kind != CMD_PAL_WR && o_cmd.last) |=> r_pixels_left == 32'd0)
        else $error("last pixel issued with pixels left");
`endif

endmodule

[hdl/zrpd_back.sv]
module zrpd_back
    import zrpd_pkg::*;
#(
    parameter int PALETTE_ENTRIES = 256,
    parameter int OUT_DEPTH       = 4
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    // command queue head
    input  logic    i_cmd_valid,
    input  t_cmd    i_cmd,
    output logic    o_cmd_pop,
    // result queue
    input  logic    i_res_pop,
    output logic    o_res_empty,
    output t_result o_res
);

    localparam int AW = $clog2(PALETTE_ENTRIES);
    localparam int CW = $clog2(OUT_DEPTH + 1);

    logic          in_range;
    logic          room;
    logic          take;
    logic          ram_we, ram_re;
    logic [23:0]   ram_rdata;
    logic [CW-1:0] res_count;
    logic          res_full;
    t_result       res_next;

    // lookup stage registers
    logic          r_s1_res;
    logic          r_s1_pixel;
    logic          r_s1_in_range;
    logic [7:0]    r_s1_idx;
    logic [7:0]    r_s1_run;
    logic          r_s1_last;

    assign in_range = ({1'b0, i_cmd.idx} < 9'(PALETTE_ENTRIES));

    // result slot reserved for a beat still in the lookup stage
    assign room = ({1'b0, res_count} + {{CW{1'b0}}, r_s1_res}) < (CW + 1)'(OUT_DEPTH);
    assign take = i_cmd_valid && (i_cmd.kind == CMD_PAL_WR || room);
    assign o_cmd_pop = take;

    assign ram_we = take && i_cmd.kind == CMD_PAL_WR && in_range;
    assign ram_re = take && i_cmd.kind == CMD_PIXEL;

    zrpd_ram #(
        .WIDTH (24),
        .DEPTH (PALETTE_ENTRIES)
    ) u_palette (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (i_cmd.idx[AW-1:0]),
        .i_wdata (i_cmd.color),
        .i_re    (ram_re),
        .i_raddr (i_cmd.idx[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    // lookup stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_res <= 1'b0;
        end else begin
            r_s1_res <= take && i_cmd.kind != CMD_PAL_WR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_s1_pixel    <= (i_cmd.kind == CMD_PIXEL);
            r_s1_in_range <= in_range;
            r_s1_idx      <= i_cmd.idx;
            r_s1_run      <= i_cmd.run;
            r_s1_last     <= i_cmd.last;
        end
    end

    // form the result beat
    always_comb begin
        if (r_s1_pixel) begin
            res_next.argb        = OPAQUE_ALPHA |
                                   {8'd0, (r_s1_in_range ? ram_rdata : 24'd0)};
            res_next.color_index = r_s1_idx;
            res_next.repeat_res  = 8'd1;
        end else begin
            res_next.argb        = 32'd0;
            res_next.color_index = 8'd0;
            res_next.repeat_res  = r_s1_run;
        end
        res_next.last_of_image = r_s1_last;
    end

    zrpd_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (OUT_DEPTH)
    ) u_res_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_s1_res),
        .i_wdata (res_next),
        .i_pop   (i_res_pop),
        .o_rdata (o_res),
        .o_empty (o_res_empty),
        .o_full  (res_full),
        .o_count (res_count)
    );

`ifndef NO_ASSERTIONS
    // reservation keeps the result queue from overflowing
    a_res_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_res |-> !res_full)
        else $error("result queue overflow");

    // a pixel or run command yields a result beat next cycle
    a_cmd_to_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && i_cmd.kind != CMD_PAL_WR) |=> r_s1_res)
        else $error("command lost in lookup stage");

    // palette writes never produce a result beat
    a_wr_no_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!take || i_cmd.kind == CMD_PAL_WR) |=> !r_s1_res)
        else $error("spurious result beat");
`endif

endmodule

[hdl/zero_run_palette_decoder_top.sv]
// Zero-run palette sprite decoder.
// Input channel (push/full): one beat per cycle while full is low. A beat is
// a palette write, a compressed stream byte or an image start. The start
// beat loads the pixel count from image_width * image_height.
// Config channel (i_cfg_valid/o_cfg_ready): ready is always high; index 0 is
// the width, 1 the height, other indexes are ignored. Values apply at start.
// Result channel (empty/pop): one beat per opaque pixel or transparent run,
// oldest first, held on the o_ ports while empty is low.
// Path: a beat passes the command queue, then the registered palette read,
// then the result queue. Throughput: one input beat per cycle while full is
// low, set by the single palette RAM port pair; palette writes and lookups
// stay in order through the command queue.
// Receiver stall: the result queue fills, the back end stops taking
// commands, the command queue fills and full rises; no beat is lost.
// Reset (synchronous, active low): queues empty, pixel count zero, so bytes
// before the first start are dropped; width and height return to 1.
// Palette contents are undefined until written.
module zero_run_palette_decoder_top
    import zrpd_pkg::*;
#(
    parameter int PALETTE_ENTRIES = 256,
    parameter int CMD_DEPTH       = 4,
    parameter int OUT_DEPTH       = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [15:0]           i_cfg_data,
    // input queue side
    input  logic                  push,
    output logic                  full,
    input  logic [1:0]            i_func,
    input  logic [7:0]            i_data_byte,
    input  logic [7:0]            i_pal_index,
    input  logic [23:0]           i_pal_color,
    // result queue side
    output logic                  empty,
    input  logic                  pop,
    output logic [31:0]           o_argb,
    output logic [7:0]            o_color_index,
    output logic [7:0]            o_repeat_res,
    output logic                  o_last_of_image
);

    logic    accept;
    logic    cmd_push, cmd_pop, cmd_empty, cmd_full;
    t_cmd    cmd_in, cmd_head;
    t_result res;
    logic [$clog2(CMD_DEPTH+1)-1:0] cmd_count;

    assign o_cfg_ready = 1'b1;
    assign full        = cmd_full;
    assign accept      = push && !cmd_full;

    zrpd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_func      (i_func),
        .i_data_byte (i_data_byte),
        .i_pal_index (i_pal_index),
        .i_pal_color (i_pal_color),
        .i_cmd_full  (cmd_full),
        .o_cmd_push  (cmd_push),
        .o_cmd       (cmd_in)
    );

    zrpd_fifo #(
        .WIDTH ($bits(t_cmd)),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_wdata (cmd_in),
        .i_pop   (cmd_pop),
        .o_rdata (cmd_head),
        .o_empty (cmd_empty),
        .o_full  (cmd_full),
        .o_count (cmd_count)
    );

    zrpd_back #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES),
        .OUT_DEPTH       (OUT_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (!cmd_empty),
        .i_cmd       (cmd_head),
        .o_cmd_pop   (cmd_pop),
        .i_res_pop   (pop),
        .o_res_empty (empty),
        .o_res       (res)
    );

    assign o_argb          = res.argb;
    assign o_color_index   = res.color_index;
    assign o_repeat_res    = res.repeat_res;
    assign o_last_of_image = res.last_of_image;

`ifndef NO_ASSERTIONS
    // full tracks the command queue fill level
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> cmd_count == ($clog2(CMD_DEPTH+1))'(CMD_DEPTH))
        else $error("full without full command queue");

    // a command at the queue head is consumed unless results back up
    a_head_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!cmd_empty && cmd_head.kind == CMD_PAL_WR) |-> cmd_pop)
        else $error("palette write stuck at queue head");

    // configuration is always accepted
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |-> o_cfg_ready)
        else $error("config write refused");
`endif

endmodule

[tb/tb_zero_run_palette_decoder_top.sv]
module tb_zero_run_palette_decoder_top
    import zrpd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          PAL_ENTRIES   = 256;
    localparam logic [1:0]  FUNC_NOISE    = 2'd3;   // undefined function, ignored
    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_B = 2'd3;
    localparam int          SETTLE_CYCLES = 6;      // pipeline depth plus margin
    localparam int          RANDOM_ITEMS  = 600;
    localparam int          IMAGE_BUDGET  = 30;

    // Predicts decoded pixels/runs and checks what the block pops out.
    class pixel_scoreboard;
        logic [23:0] palette [PAL_ENTRIES];
        bit          written [PAL_ENTRIES];
        bit          run_armed;
        logic [31:0] pixels_left;
        logic [15:0] width_reg;
        logic [15:0] height_reg;
        t_result     pixel_q [$];
        int          errors;
        int          checked;

        function new();
            run_armed   = 1'b0;
            pixels_left = '0;
            width_reg   = 16'd1;
            height_reg  = 16'd1;
            errors      = 0;
            checked     = 0;
            foreach (written[i]) written[i] = 1'b0;
        endfunction

        function int pending();
            return pixel_q.size();
        endfunction

        function void write_reg(logic [CFG_ADDR_W-1:0] addr, logic [15:0] data);
            if (addr == CFG_WIDTH)
                width_reg = data;
            else if (addr == CFG_HEIGHT)
                height_reg = data;
        endfunction

        // advance the decoder state by one accepted input beat
        function void note_input(logic [1:0] func, logic [7:0] data_b,
                                 logic [7:0] idx, logic [23:0] color);
            t_result     want;
            logic [31:0] run_len;
            case (func)
                FUNC_PAL_WR: begin
                    if (idx < PAL_ENTRIES) begin
                        palette[idx] = color;
                        written[idx] = 1'b1;
                    end
                end
                FUNC_START: begin
                    pixels_left = {16'h0, width_reg} * {16'h0, height_reg};
                    run_armed   = 1'b0;
                end
                FUNC_BYTE: begin
                    if (pixels_left != 0) begin
                        if (run_armed) begin
                            // count byte: zero means one, clip at image end
                            run_len = (data_b == 8'd0) ? 32'd1 : {24'h0, data_b};
                            if (run_len > pixels_left)
                                run_len = pixels_left;
                            want.argb          = '0;
                            want.color_index   = '0;
                            want.repeat_res    = run_len[7:0];
                            want.last_of_image = (run_len == pixels_left);
                            pixels_left        = pixels_left - run_len;
                            run_armed          = 1'b0;
                            pixel_q.push_back(want);
                        end else if (data_b == 8'd0) begin
                            run_armed = 1'b1;
                        end else begin
                            want.argb = OPAQUE_ALPHA |
                                {8'h0, (data_b < PAL_ENTRIES) ? palette[data_b] : 24'h0};
                            want.color_index   = data_b;
                            want.repeat_res    = 8'd1;
                            want.last_of_image = (pixels_left == 32'd1);
                            pixels_left        = pixels_left - 32'd1;
                            pixel_q.push_back(want);
                        end
                    end
                end
                default: ;
            endcase
        endfunction

        task report(string msg);
            $display("[%0t] MISMATCH: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(t_result got);
            t_result want;
            if (pixel_q.size() == 0) begin
                report($sformatf("unexpected result argb=%h idx=%0d rep=%0d last=%0b",
                                 got.argb, got.color_index, got.repeat_res,
                                 got.last_of_image));
                return;
            end
            want = pixel_q.pop_front();
            checked++;
            if (got.argb !== want.argb)
                report($sformatf("argb got %h want %h", got.argb, want.argb));
            if (got.color_index !== want.color_index)
                report($sformatf("color_index got %0d want %0d",
                                 got.color_index, want.color_index));
            if (got.repeat_res !== want.repeat_res)
                report($sformatf("repeat_res got %0d want %0d",
                                 got.repeat_res, want.repeat_res));
            if (got.last_of_image !== want.last_of_image)
                report($sformatf("last_of_image got %0b want %0b",
                                 got.last_of_image, want.last_of_image));
        endtask
    endclass

    logic                  i_clk           = 1'b0;
    logic                  i_rst_n         = 1'b0;
    logic                  i_cfg_valid     = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_ADDR_W-1:0] i_cfg_addr      = '0;
    logic [15:0]           i_cfg_data      = '0;
    logic                  push            = 1'b0;
    logic                  full;
    logic [1:0]            i_func          = FUNC_PAL_WR;
    logic [7:0]            i_data_byte     = '0;
    logic [7:0]            i_pal_index     = '0;
    logic [23:0]           i_pal_color     = '0;
    logic                  empty;
    logic                  pop             = 1'b0;
    logic [31:0]           o_argb;
    logic [7:0]            o_color_index;
    logic [7:0]            o_repeat_res;
    logic                  o_last_of_image;

    pixel_scoreboard sb = new();
    bit              no_idle     = 1'b0;
    int              beats_sent  = 0;
    int              beats_noise = 0;
    int              size_count  = 0;

    zero_run_palette_decoder_top i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_data      (i_cfg_data),
        .push            (push),
        .full            (full),
        .i_func          (i_func),
        .i_data_byte     (i_data_byte),
        .i_pal_index     (i_pal_index),
        .i_pal_color     (i_pal_color),
        .empty           (empty),
        .pop             (pop),
        .o_argb          (o_argb),
        .o_color_index   (o_color_index),
        .o_repeat_res    (o_repeat_res),
        .o_last_of_image (o_last_of_image)
    );

    always #5 i_clk = ~i_clk;

    // one input beat, after a random gap unless no_idle is set
    task automatic send_item(logic [1:0] func, logic [7:0] data_b,
                             logic [7:0] idx, logic [23:0] color);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push        <= 1'b1;
        i_func      <= func;
        i_data_byte <= data_b;
        i_pal_index <= idx;
        i_pal_color <= color;
        do @(posedge i_clk); while (full !== 1'b0);
        sb.note_input(func, data_b, idx, color);
        if (func == FUNC_NOISE)
            beats_noise++;
        else
            beats_sent++;
    endtask

    task automatic send_byte(logic [7:0] data_b);
        send_item(FUNC_BYTE, data_b, 8'($urandom), 24'($urandom));
    endtask

    task automatic send_pal(logic [7:0] idx, logic [23:0] color);
        send_item(FUNC_PAL_WR, 8'($urandom), idx, color);
    endtask

    task automatic send_start();
        send_item(FUNC_START, 8'($urandom), 8'($urandom), 24'($urandom));
    endtask

    // hold input until every predicted result is out and the pipe is quiet
    task automatic settle();
        push <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_ADDR_W-1:0] addr, logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        sb.write_reg(addr, data);
    endtask

    task automatic set_image_size(logic [15:0] w, logic [15:0] h);
        cfg_write(CFG_WIDTH, w);
        cfg_write(CFG_HEIGHT, h);
        if ($urandom_range(0, 3) == 0)
            cfg_write($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B, 16'($urandom));
        i_cfg_valid <= 1'b0;
        size_count++;
    endtask

    // a nonzero index whose palette entry has been loaded
    function automatic logic [7:0] pick_pixel();
        logic [7:0] v;
        do v = 8'($urandom_range(1, 255)); while (!sb.written[v]);
        return v;
    endfunction

    // next stream byte: run count when armed, else zero marker or pixel
    function automatic logic [7:0] pick_stream_byte();
        int r;
        r = $urandom_range(0, 99);
        if (sb.run_armed) begin
            if (r < 40) return 8'($urandom_range(1, 4));
            if (r < 50) return 8'd0;
            if (r < 60) return 8'd255;
            return 8'($urandom);
        end
        if (r < 25) return 8'd0;
        return pick_pixel();
    endfunction

    // one image: start, well-formed stream with some noise, trailing bytes
    task automatic run_image(bit force_pause);
        int budget;
        int r;
        int trail;
        budget = IMAGE_BUDGET;
        send_start();
        while (budget > 0 && sb.pixels_left != 0) begin
            r = $urandom_range(0, 99);
            if (force_pause && budget == IMAGE_BUDGET / 2) begin
                settle();
                force_pause = 1'b0;
            end
            if (r < 8) begin
                send_pal(8'($urandom), 24'($urandom));
                budget--;
            end else if (r < 10) begin
                send_item(FUNC_NOISE, 8'($urandom), 8'($urandom), 24'($urandom));
            end else if (r < 12) begin
                send_start();
                budget--;
            end else if (r < 14) begin
                settle();
            end else begin
                send_byte(pick_stream_byte());
                budget--;
            end
        end
        // bytes past the end of the image are dropped
        if (sb.pixels_left == 0) begin
            trail = $urandom_range(1, 3);
            repeat (trail) send_byte($urandom_range(0, 1) ? pick_pixel() : 8'd0);
        end
    endtask

    // result side: random stalls unless no_idle is set, check every popped beat
    initial begin
        t_result got;
        int      stall;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 10);
            if (stall > 0) begin
                pop <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty !== 1'b0);
            got.argb          = o_argb;
            got.color_index   = o_color_index;
            got.repeat_res    = o_repeat_res;
            got.last_of_image = o_last_of_image;
            sb.check_result(got);
        end
    end

    // stimulus
    initial begin
        int          phase;
        logic [15:0] w;
        logic [15:0] h;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: zero byte before any start is dropped
        send_byte(8'd0);
        send_pal(8'd255, 24'hFF_FFFF);
        send_pal(8'd1, 24'h56_3412);
        send_pal(8'd0, 24'h00_0000);
        // reset size is one pixel: second byte falls past the image
        send_start();
        send_byte(8'd255);
        send_byte(8'd1);
        settle();
        set_image_size(16'd4, 16'd2);
        // pixels, zero count repaired to one, run clipped at the image end
        send_start();
        send_byte(8'd1);
        send_byte(8'd255);
        send_byte(8'd0);
        send_byte(8'd0);
        send_byte(8'd0);
        send_byte(8'd255);
        send_byte(8'd255);
        send_item(FUNC_NOISE, 8'hFF, 8'hFF, 24'hFF_FFFF);
        // start while a count is awaited disarms the run
        send_start();
        send_byte(8'd0);
        send_start();
        send_byte(8'd1);
        // palette update takes effect for the very next lookup
        send_pal(8'd1, 24'hA9_CBED);
        send_byte(8'd1);
        send_byte(8'd0);
        send_byte(8'd6);

        // random phases, each with its own image size
        phase = 0;
        while (beats_sent < RANDOM_ITEMS + 25) begin
            settle();
            case (phase)
                0: begin w = 16'hFFFF; h = 16'hFFFF; end
                1: begin w = 16'd0;    h = 16'd7;    end
                2: begin w = 16'd9;    h = 16'd0;    end
                3: begin w = 16'd1;    h = 16'hFFFF; end
                4: begin w = 16'hFFFF; h = 16'd1;    end
                5: begin w = 16'd1;    h = 16'd1;    end
                default: begin
                    if ($urandom_range(0, 6) == 0) begin
                        w = 16'($urandom_range(1, 300));
                        h = 16'd1;
                    end else begin
                        w = 16'($urandom_range(1, 8));
                        h = 16'($urandom_range(1, 6));
                    end
                end
            endcase
            set_image_size(w, h);
            no_idle = ($urandom_range(0, 3) == 0);
            // early phase loads a good share of the palette
            if (phase == 0)
                repeat (40) send_pal(8'($urandom), 24'($urandom));
            repeat ($urandom_range(1, 3))
                run_image(phase == 6 || $urandom_range(0, 9) == 0);
            phase++;
        end

        settle();
        repeat (10) @(posedge i_clk);
        $display("Covered %0d input beats plus %0d undefined-function beats, %0d sizes.",
                 beats_sent, beats_noise, size_count);
        $display("Checked %0d pixels and transparent runs against the prediction.",
                 sb.checked);
        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("Timeout waiting for the decoder");
        $display("Test completed with failures");
        $finish;
    end

endmodule

[zero_run_palette_decoder_top.f]
hdl/zrpd_pkg.sv
hdl/zrpd_ram.sv
hdl/zrpd_fifo.sv
hdl/zrpd_front.sv
hdl/zrpd_back.sv
hdl/zero_run_palette_decoder_top.sv
tb/tb_zero_run_palette_decoder_top.sv
